/* rtl/etmrm_pkg.sv */
// ---------------------------------------------------------------------------
// Echo trimmed-mean range mapper package
// Register indexes and fixed constants shared by the mapper.
// ---------------------------------------------------------------------------
package etmrm_pkg;

  typedef enum logic [1:0] {
    REG_MIN_IN  = 2'd0,
    REG_MAX_IN  = 2'd1,
    REG_MIN_OUT = 2'd2,
    REG_MAX_OUT = 2'd3
  } reg_idx_t;

  localparam logic [15:0] VALID_ABOVE = 16'd50;
  localparam logic [2:0]  FAIL_SAT    = 3'd4;
  localparam logic [2:0]  FAIL_LIMIT  = 3'd3;
  localparam logic [8:0]  CM_DIVISOR  = 9'd291;

endpackage

/* rtl/echo_trimmed_mean_range_mapper_unit.sv */
// One request at a time: the next request is taken only after the result has
// been accepted with out_ready; SW = 16 + clog2(WINDOW+1).
// The shared restoring divider retires one bit a cycle: SW for the mean, 20 for the
// centimetres, 34 for the mapping. Reset clears ring, position, failure run; ranges 0..500.
// ---------------------------------------------------------------------------
// Echo trimmed-mean range mapper
// Filters echo widths by a ring mean, trimmed once full, converts to centimetres and
// maps linearly into a clamped output range, using bit-serial dividers.
// ---------------------------------------------------------------------------
module echo_trimmed_mean_range_mapper_unit #(
  parameter int WINDOW = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_echo_width_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_mapped_value,
  output logic               out_available,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);
  import etmrm_pkg::*;

  localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SW = 16 + $clog2(WINDOW + 1);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(WINDOW - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(WINDOW);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_MEAN, S_CM, S_MAP, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] ring_r [WINDOW];
  logic [PW-1:0] pos_r, scan_r;
  logic [2:0] fail_r;
  logic signed [15:0] min_in_r, max_in_r, min_out_r, max_out_r;
  logic [15:0] width_r, lo_r, hi_r;
  logic [SW-1:0] sum_r;
  logic [CW-1:0] cnt_r;
  // Shared restoring divider: remainder, quotient/dividend shift, divisor.
  logic [33:0] rem_r;
  logic [33:0] quo_r;
  logic [33:0] dvs_r;
  logic [5:0]  bit_r;
  logic        neg_r;
  logic signed [15:0] res_r;
  logic avail_r;
  logic [15:0] cm_r;

  logic [15:0] s;
  logic [34:0] trial;
  logic signed [33:0] numer, den;
  logic signed [16:0] dnum;

  assign s     = ring_r[scan_r];
  assign trial = {rem_r, quo_r[33]} - {1'b0, dvs_r};
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_mapped_value = res_r;
  assign out_available = avail_r;
  assign dnum = 17'(max_in_r) - 17'(min_in_r);
  assign numer = (34'(signed'(cm_r)) - 34'(min_in_r)) *
                 (34'(max_out_r) - 34'(min_out_r));
  assign den = 34'(dnum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < WINDOW; i++) ring_r[i] <= '0;
      pos_r <= '0; fail_r <= '0; scan_r <= '0;
      min_in_r <= 16'sd0; max_in_r <= 16'sd500;
      min_out_r <= 16'sd0; max_out_r <= 16'sd500;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_MIN_IN:  min_in_r  <= cfg_wdata;
          REG_MAX_IN:  max_in_r  <= cfg_wdata;
          REG_MIN_OUT: min_out_r <= cfg_wdata;
          REG_MAX_OUT: max_out_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: if (in_valid) begin
          width_r <= in_echo_width_us;
          if (in_echo_width_us > VALID_ABOVE) begin
            pos_r <= (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
            ring_r[(pos_r == LAST_POS) ? '0 : pos_r + 1'b1] <= in_echo_width_us;
            fail_r <= '0;
          end else if (fail_r < FAIL_SAT) begin
            fail_r <= fail_r + 1'b1;
          end
          scan_r <= '0; sum_r <= '0; cnt_r <= '0; lo_r <= '0; hi_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (s != 0) begin
            if (cnt_r == 0 || s < lo_r) lo_r <= s;
            if (s > hi_r) hi_r <= s;
            sum_r <= sum_r + SW'(s);
            cnt_r <= cnt_r + 1'b1;
          end
          if (scan_r == LAST_POS) state_r <= S_MEAN;
          else scan_r <= scan_r + 1'b1;
          bit_r <= '0;
        end
        S_MEAN: begin
          if (bit_r == 0) begin
            if (cnt_r == 0) begin
              quo_r <= 34'(width_r * 19'd5) << 14; bit_r <= '0;
              dvs_r <= 34'(CM_DIVISOR); rem_r <= '0;
              state_r <= S_CM;
            end else begin
              rem_r <= '0;
              if (cnt_r == FULL_CNT) begin
                quo_r <= 34'(sum_r - SW'(lo_r) - SW'(hi_r)) << (34 - SW);
                dvs_r <= 34'(cnt_r - CW'(2));
              end else begin
                quo_r <= 34'(sum_r) << (34 - SW);
                dvs_r <= 34'(cnt_r);
              end
              bit_r <= 6'd1;
            end
          end else begin
            if (!trial[34]) begin
              rem_r <= trial[33:0]; quo_r <= {quo_r[32:0], 1'b1};
            end else begin
              rem_r <= {rem_r[32:0], quo_r[33]}; quo_r <= {quo_r[32:0], 1'b0};
            end
            if (bit_r == 6'(SW)) begin
              state_r <= S_CM; bit_r <= 6'd63;
            end else bit_r <= bit_r + 1'b1;
          end
        end
        S_CM: begin
          if (bit_r == 6'd63) begin
            // Mean sits in the low bits of quo_r after the shift-in.
            quo_r <= 34'(quo_r[15:0] * 19'd5) << 14; rem_r <= '0;
            dvs_r <= 34'(CM_DIVISOR); bit_r <= '0;
          end else begin
            if (!trial[34]) begin
              rem_r <= trial[33:0]; quo_r <= {quo_r[32:0], 1'b1};
            end else begin
              rem_r <= {rem_r[32:0], quo_r[33]}; quo_r <= {quo_r[32:0], 1'b0};
            end
            if (bit_r == 6'd19) begin
              state_r <= S_MAP; bit_r <= 6'd63;
            end else bit_r <= bit_r + 1'b1;
          end
        end
        S_MAP: begin
          if (bit_r == 6'd63) begin
            cm_r <= quo_r[15:0];
            bit_r <= 6'd62;
          end else if (bit_r == 6'd62) begin
            neg_r <= numer[33] ^ den[33];
            quo_r <= numer[33] ? -numer : numer;
            dvs_r <= den[33] ? -den : den;
            rem_r <= '0; bit_r <= '0;
          end else begin
            if (!trial[34]) begin
              rem_r <= trial[33:0]; quo_r <= {quo_r[32:0], 1'b1};
            end else begin
              rem_r <= {rem_r[32:0], quo_r[33]}; quo_r <= {quo_r[32:0], 1'b0};
            end
            if (bit_r == 6'd33) state_r <= S_FIN;
            else bit_r <= bit_r + 1'b1;
          end
        end
        S_FIN: begin
          logic signed [34:0] v;
          logic signed [15:0] lo_b, hi_b;
          v = (dnum == 0) ? 35'(min_out_r)
              : (neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r}))
                + 35'(min_out_r);
          lo_b = (min_out_r < max_out_r) ? min_out_r : max_out_r;
          hi_b = (min_out_r < max_out_r) ? max_out_r : min_out_r;
          if (fail_r > FAIL_LIMIT) begin
            res_r <= '0; avail_r <= 1'b0;
          end else begin
            avail_r <= 1'b1;
            if (v < 35'(lo_b)) res_r <= lo_b;
            else if (v > 35'(hi_b)) res_r <= hi_b;
            else res_r <= v[15:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* test/echo_trimmed_mean_range_mapper_unit_tb.sv */
// ---------------------------------------------------------------------------
// Echo trimmed-mean range mapper testbench
// Drives echo widths through the mapper under random idling and back
// pressure, predicts each mapped-value/availability pair and compares in order.
// ---------------------------------------------------------------------------
module echo_trimmed_mean_range_mapper_unit_tb;
  import etmrm_pkg::*;

  localparam int WIN = 5;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [15:0] mapped;
    logic               avail;
  } echo_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [15:0]        in_echo_width_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_mapped_value;
  logic               out_available;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  // Predictor state and register copy.
  logic [15:0]  ring_q [WIN];
  int           ring_pos;
  int           fail_run;
  int           reg_min_in, reg_max_in, reg_min_out, reg_max_out;

  echo_result_t distance_fifo[$];
  int           mismatch_count = 0;
  int           idle_count = 0;
  bit           hold_off = 1'b0;

  echo_trimmed_mean_range_mapper_unit #(.WINDOW(WIN)) dut (.*);

  always #5 clk = ~clk;

  function automatic echo_result_t predict_echo(input logic [15:0] w);
    longint lo, hi, sum, cnt, width, dist_cm, value, den, lo_b, hi_b;
    echo_result_t r;
    width = w;
    lo = 0; hi = 0; sum = 0; cnt = 0;
    if (w > VALID_ABOVE) begin
      ring_pos = (ring_pos + 1 >= WIN) ? 0 : ring_pos + 1;
      ring_q[ring_pos] = w;
      fail_run = 0;
    end else if (fail_run < FAIL_SAT) begin
      fail_run++;
    end
    for (int i = 0; i < WIN; i++) begin
      if (ring_q[i] != 0) begin
        if (cnt == 0 || ring_q[i] < lo) lo = ring_q[i];
        if (ring_q[i] > hi) hi = ring_q[i];
        sum += ring_q[i];
        cnt++;
      end
    end
    if (cnt == WIN) begin
      sum -= lo + hi;
      cnt -= 2;
    end
    if (cnt > 0) width = sum / cnt;
    dist_cm = (width * 5) / 291;
    den = reg_max_in - reg_min_in;
    if (den == 0) value = reg_min_out;
    else value = (dist_cm - reg_min_in) * (reg_max_out - reg_min_out) / den + reg_min_out;
    if (reg_min_out < reg_max_out) begin
      lo_b = reg_min_out; hi_b = reg_max_out;
    end else begin
      lo_b = reg_max_out; hi_b = reg_min_out;
    end
    if (value < lo_b) value = lo_b;
    else if (value > hi_b) value = hi_b;
    if (fail_run <= FAIL_LIMIT) begin
      r.mapped = value[15:0]; r.avail = 1'b1;
    end else begin
      r.mapped = '0; r.avail = 1'b0;
    end
    return r;
  endfunction

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_MIN_IN:  reg_min_in = $signed(val);
      REG_MAX_IN:  reg_max_in = $signed(val);
      REG_MIN_OUT: reg_min_out = $signed(val);
      default:     reg_max_out = $signed(val);
    endcase
  endtask

  task automatic set_ranges(input logic [15:0] a, b, c, d);
    write_reg(REG_MIN_IN, a);
    write_reg(REG_MAX_IN, b);
    write_reg(REG_MIN_OUT, c);
    write_reg(REG_MAX_OUT, d);
    cfg_we <= 1'b0;
  endtask

  // One request, with a random gap ahead of it unless told otherwise.
  // Valid stays high after acceptance; a gap or wait_idle lowers it.
  task automatic send_echo(input logic [15:0] w, input bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(14);
    if ($urandom_range(3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_echo_width_us <= w;
    do @(posedge clk); while (!in_ready);
    distance_fifo.push_back(predict_echo(w));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (distance_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_reading();
    case ($urandom_range(9))
      0:       return 16'($urandom_range(50));
      1:       return 16'($urandom);
      2:       return 16'($urandom_range(65535, 60000));
      default: return 16'($urandom_range(60000, 51));
    endcase
  endfunction

  // Receiver: random ready per result, or a long hold-off when asked.
  initial begin
    int wait_cycles;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (!out_ready) begin
        wait_cycles = ($urandom_range(3) == 0) ? 0 : $urandom_range(14);
        repeat (wait_cycles) @(posedge clk);
        if (!hold_off) out_ready <= 1'b1;
      end else if (out_valid) begin
        // Accepted on this edge; decide whether the next one waits.
        if ($urandom_range(1) == 0) out_ready <= 1'b0;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    echo_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (distance_fifo.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result mapped=%0d avail=%0b", out_mapped_value, out_available);
      end else begin
        exp_r = distance_fifo.pop_front();
        if (exp_r.mapped !== out_mapped_value || exp_r.avail !== out_available) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected mapped=%0d avail=%0b, got mapped=%0d avail=%0b",
                     exp_r.mapped, exp_r.avail, out_mapped_value, out_available);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_defaults();
    send_echo(16'd0);
    send_echo(16'd50);
    send_echo(16'd51);
    send_echo(16'd60000);
    send_echo(16'hFFFF);
    for (int i = 0; i < 5; i++) send_echo(16'd0);
    for (int i = 0; i < 6; i++) send_echo(16'd1000 + 16'(i * 3000));
    send_echo(16'd10);
    wait_idle();
  endtask

  task automatic test_special_ranges();
    set_ranges(16'd100, 16'd100, 16'hFF00, 16'd700);
    send_echo(16'd5000);
    send_echo(16'd40000);
    wait_idle();
    set_ranges(16'd0, 16'd300, 16'd900, 16'hFC00);
    send_echo(16'd3000);
    send_echo(16'd30000);
    wait_idle();
    set_ranges(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_echo(16'd58000);
    send_echo(16'd0);
    wait_idle();
    set_ranges(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_echo(16'd20000);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      set_ranges(16'($urandom_range(100)), 16'($urandom_range(1100, 200)),
                 16'($urandom), 16'($urandom));
      for (int i = 0; i < 170; i++) send_echo(rand_reading());
      wait_idle();
    end
    set_ranges(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    for (int i = 0; i < 100; i++) send_echo(rand_reading());
    wait_idle();
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_echo(rand_reading(), 1'b1);
    join
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < WIN; i++) ring_q[i] = '0;
    ring_pos = 0;
    fail_run = 0;
    reg_min_in = 0; reg_max_in = 500; reg_min_out = 0; reg_max_out = 500;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_special_ranges();
    test_backpressure();
    test_random_traffic();
    if (mismatch_count == 0 && distance_fifo.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
